// File: sv/fifo_queue_lock_manager_top_defines.svh
// ----------------------------------------------------------------------------
// fifo_queue_lock_manager_top_defines.svh
// Assertion macros used by the lock manager top level.
// ----------------------------------------------------------------------------
`ifndef FIFO_QUEUE_LOCK_MANAGER_TOP_DEFINES_SVH
`define FIFO_QUEUE_LOCK_MANAGER_TOP_DEFINES_SVH

// Same-cycle implication, checked on clk with reset disabling the check.
`define FQLM_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on clk with reset disabling the check.
`define FQLM_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: sv/fqlm_pkg.sv
// ----------------------------------------------------------------------------
// fqlm_pkg
// Types and constants of the queue lock manager.
// ----------------------------------------------------------------------------
`default_nettype none

package fqlm_pkg;

	localparam int ID_W = 4;
	localparam int ST_W = 2;
	localparam int QDEPTH = 2;

	localparam logic OP_ACQUIRE = 1'b0;
	localparam logic OP_RELEASE = 1'b1;

	localparam logic [ST_W-1:0] ST_OK = 2'd0;
	localparam logic [ST_W-1:0] ST_QUEUED = 2'd1;
	localparam logic [ST_W-1:0] ST_DUP = 2'd2;
	localparam logic [ST_W-1:0] ST_NOT_HOLDER = 2'd3;

	// Class of a request as decided by the front end.
	typedef enum logic [1:0] {
		CLS_ACQ,
		CLS_REL,
		CLS_BAD_ACQ,
		CLS_BAD_REL
	} cls_t;

	typedef struct packed {
		cls_t cls;
		logic [ID_W-1:0] id;
	} item_t;

endpackage

`default_nettype wire

// File: sv/fqlm_front.sv
// ----------------------------------------------------------------------------
// fqlm_front
// Accepts requests, classifies them and holds them in a short queue.
// ----------------------------------------------------------------------------
`default_nettype none

module fqlm_front #(
	parameter int NUM_REQUESTERS = 16
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          in_valid,
	output logic                         in_ready,
	input  wire                          op,
	input  wire  [fqlm_pkg::ID_W-1:0]    requester,
	output logic                         q_valid,
	input  wire                          q_ready,
	output fqlm_pkg::item_t              q_item
);

	localparam int PTR_W = (fqlm_pkg::QDEPTH > 1) ? $clog2(fqlm_pkg::QDEPTH) : 1;
	localparam int CNT_W = $clog2(fqlm_pkg::QDEPTH + 1);
	localparam int CMP_W = 10;

	fqlm_pkg::item_t  queue_q [fqlm_pkg::QDEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	fqlm_pkg::item_t  new_item;
	logic             in_range;
	logic             push;
	logic             pop;

	// An identity at or above the requester count is never tracked.
	assign in_range = CMP_W'(requester) < CMP_W'(NUM_REQUESTERS);

	always_comb begin
		new_item.id = requester;
		if (op == fqlm_pkg::OP_RELEASE) begin
			new_item.cls = in_range ? fqlm_pkg::CLS_REL : fqlm_pkg::CLS_BAD_REL;
		end else begin
			new_item.cls = in_range ? fqlm_pkg::CLS_ACQ : fqlm_pkg::CLS_BAD_ACQ;
		end
	end

	assign in_ready = count_q != CNT_W'(fqlm_pkg::QDEPTH);
	assign q_valid  = count_q != '0;
	assign q_item   = queue_q[rd_ptr_q];
	assign push     = in_valid && in_ready;
	assign pop      = q_valid && q_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(fqlm_pkg::QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(fqlm_pkg::QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[wr_ptr_q] <= new_item;
		end
	end

endmodule

`default_nettype wire

// File: sv/fqlm_back.sv
// ----------------------------------------------------------------------------
// fqlm_back
// Executes classified requests against the lock queue and registers results.
// ----------------------------------------------------------------------------
`default_nettype none

module fqlm_back #(
	parameter int NUM_REQUESTERS = 16
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          q_valid,
	output logic                         q_ready,
	input  fqlm_pkg::item_t              q_item,
	output logic                         out_valid,
	input  wire                          out_ready,
	output logic                         grant_valid,
	output logic [fqlm_pkg::ID_W-1:0]    grant_to,
	output logic [fqlm_pkg::ST_W-1:0]    status,
	output logic                         queue_empty
);

	// Only identities that fit the requester field can ever be linked.
	localparam int DEPTH = (NUM_REQUESTERS < (1 << fqlm_pkg::ID_W)) ?
		NUM_REQUESTERS : (1 << fqlm_pkg::ID_W);
	localparam int IDX_W = $clog2(DEPTH);

	logic [fqlm_pkg::ID_W-1:0] tail_id_q;
	logic                      tail_valid_q;
	logic [fqlm_pkg::ID_W-1:0] holder_id_q;
	logic [fqlm_pkg::ID_W-1:0] succ_id_q [DEPTH];
	logic [DEPTH-1:0]          succ_valid_q;
	logic [DEPTH-1:0]          mark_q;

	logic                      out_valid_q;
	logic                      grant_valid_q;
	logic [fqlm_pkg::ID_W-1:0] grant_to_q;
	logic [fqlm_pkg::ST_W-1:0] status_q;
	logic                      queue_empty_q;

	logic [IDX_W-1:0]          r_idx;
	logic [IDX_W-1:0]          t_idx;
	logic                      pop;

	logic                      res_grant;
	logic [fqlm_pkg::ID_W-1:0] res_to;
	logic [fqlm_pkg::ST_W-1:0] res_status;
	logic                      tail_valid_d;
	logic [fqlm_pkg::ID_W-1:0] tail_id_d;
	logic [fqlm_pkg::ID_W-1:0] holder_id_d;
	logic                      set_mark;
	logic                      clr_mark;
	logic                      clr_succ;
	logic                      link_tail;

	assign r_idx   = q_item.id[IDX_W-1:0];
	assign t_idx   = tail_id_q[IDX_W-1:0];
	assign q_ready = !out_valid_q || out_ready;
	assign pop     = q_valid && q_ready;

	always_comb begin
		res_grant    = 1'b0;
		res_to       = '0;
		res_status   = fqlm_pkg::ST_OK;
		tail_valid_d = tail_valid_q;
		tail_id_d    = tail_id_q;
		holder_id_d  = holder_id_q;
		set_mark     = 1'b0;
		clr_mark     = 1'b0;
		clr_succ     = 1'b0;
		link_tail    = 1'b0;
		case (q_item.cls)
			fqlm_pkg::CLS_ACQ: begin
				if (mark_q[r_idx]) begin
					res_status = fqlm_pkg::ST_DUP;
				end else begin
					set_mark  = 1'b1;
					clr_succ  = 1'b1;
					tail_id_d = q_item.id;
					if (!tail_valid_q) begin
						tail_valid_d = 1'b1;
						holder_id_d  = q_item.id;
						res_grant    = 1'b1;
						res_to       = q_item.id;
					end else begin
						link_tail  = 1'b1;
						res_status = fqlm_pkg::ST_QUEUED;
					end
				end
			end
			fqlm_pkg::CLS_REL: begin
				if (!tail_valid_q || holder_id_q != q_item.id) begin
					res_status = fqlm_pkg::ST_NOT_HOLDER;
				end else begin
					clr_mark = 1'b1;
					if (succ_valid_q[r_idx]) begin
						clr_succ    = 1'b1;
						holder_id_d = succ_id_q[r_idx];
						res_grant   = 1'b1;
						res_to      = succ_id_q[r_idx];
					end else begin
						tail_valid_d = 1'b0;
						tail_id_d    = '0;
					end
				end
			end
			fqlm_pkg::CLS_BAD_ACQ: begin
				res_status = fqlm_pkg::ST_DUP;
			end
			default: begin
				res_status = fqlm_pkg::ST_NOT_HOLDER;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tail_id_q    <= '0;
			tail_valid_q <= 1'b0;
			holder_id_q  <= '0;
			succ_valid_q <= '0;
			mark_q       <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (pop) begin
				tail_id_q    <= tail_id_d;
				tail_valid_q <= tail_valid_d;
				holder_id_q  <= holder_id_d;
				if (set_mark) begin
					mark_q[r_idx] <= 1'b1;
				end
				if (clr_mark) begin
					mark_q[r_idx] <= 1'b0;
				end
				// The tail is always marked, so it never equals a new requester.
				if (clr_succ) begin
					succ_valid_q[r_idx] <= 1'b0;
				end
				if (link_tail) begin
					succ_valid_q[t_idx] <= 1'b1;
				end
			end
			if (pop) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			if (link_tail) begin
				succ_id_q[t_idx] <= q_item.id;
			end
			grant_valid_q <= res_grant;
			grant_to_q    <= res_to;
			status_q      <= res_status;
			queue_empty_q <= !tail_valid_d;
		end
	end

	assign out_valid   = out_valid_q;
	assign grant_valid = grant_valid_q;
	assign grant_to    = grant_to_q;
	assign status      = status_q;
	assign queue_empty = queue_empty_q;

endmodule

`default_nettype wire

// File: sv/fifo_queue_lock_manager_top.sv
// ----------------------------------------------------------------------------
// fifo_queue_lock_manager_top
// First-come lock manager built on a tail pointer and per-requester links.
// ----------------------------------------------------------------------------
// Usage:
//   The request channel (in_valid, in_ready, op, requester) carries one
//   acquire or release per transfer. The result channel (out_valid,
//   out_ready, grant_valid, grant_to, status, queue_empty) returns exactly
//   one result per request, in request order.
//   The front end classifies a request and writes it into a two-entry
//   queue, and the back end takes it from that queue, updates the lock
//   state and registers its result. Throughput is one request per cycle
//   while out_ready stays high, bounded by the single update of the tail,
//   holder and link registers the back end makes in each cycle.
//   When the receiver stalls, the result stays in its output register and
//   the queue absorbs up to two more requests before in_ready drops.
//   Reset empties the lock queue, clears every link and queued flag, and
//   drops out_valid and q_valid; the block takes requests as soon as
//   reset is released.
// ----------------------------------------------------------------------------
`default_nettype none

`include "fifo_queue_lock_manager_top_defines.svh"

module fifo_queue_lock_manager_top #(
	parameter int NUM_REQUESTERS = 16
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          in_valid,
	output logic                         in_ready,
	input  wire                          op,
	input  wire  [fqlm_pkg::ID_W-1:0]    requester,
	output logic                         out_valid,
	input  wire                          out_ready,
	output logic                         grant_valid,
	output logic [fqlm_pkg::ID_W-1:0]    grant_to,
	output logic [fqlm_pkg::ST_W-1:0]    status,
	output logic                         queue_empty
);

	// Classified requests travel from the front end to the back end here.
	logic            q_valid;
	logic            q_ready;
	fqlm_pkg::item_t q_item;

	// The front end decides whether a requester identity is in range and
	// buffers the classified request.
	fqlm_front #(
		.NUM_REQUESTERS(NUM_REQUESTERS)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.op(op),
		.requester(requester),
		.q_valid(q_valid),
		.q_ready(q_ready),
		.q_item(q_item)
	);

	// The back end owns the lock state and takes a request whenever its
	// output register is free or being emptied in the same cycle.
	fqlm_back #(
		.NUM_REQUESTERS(NUM_REQUESTERS)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.q_valid(q_valid),
		.q_ready(q_ready),
		.q_item(q_item),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.grant_valid(grant_valid),
		.grant_to(grant_to),
		.status(status),
		.queue_empty(queue_empty)
	);

	// A grant only comes with a successful request and leaves a holder.
	`FQLM_ASSERT_IMPL(a_grant_ok, out_valid && grant_valid, status == fqlm_pkg::ST_OK, "grant without ok status")
	`FQLM_ASSERT_IMPL(a_grant_holder, out_valid && grant_valid, !queue_empty, "grant on an empty queue")
	// A request that waits must find the lock held.
	`FQLM_ASSERT_IMPL(a_queued_held, out_valid && status == fqlm_pkg::ST_QUEUED, !queue_empty, "queued on an empty queue")
	// A backed-up queue always has a result waiting at the output.
	`FQLM_ASSERT_NEXT(a_backpressure, !in_ready, out_valid, "queue full without a pending result")

endmodule

`default_nettype wire

// File: verif/fifo_queue_lock_manager_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fifo_queue_lock_manager_top_tb
// Self-checking testbench for the first-come queue lock manager.
// A directed sequence walks through grants, queued waiters, hand-overs,
// duplicate acquires and releases by agents that do not hold the lock. A
// long random sequence follows, mostly well-formed lock traffic with some
// noise mixed in. A scoreboard keeps its own copy of the tail, holder and
// successor links, predicts the result of every request transfer, and
// compares each result transfer against the oldest prediction.
// ----------------------------------------------------------------------------

module fifo_queue_lock_manager_top_tb;

	localparam int REQUESTERS = 16;
	localparam int RANDOM_REQUESTS = 1000;
	// Results come back through the queue and the output register, so a short
	// drain window after the last expected result is plenty.
	localparam int DRAIN_CYCLES = 10;
	localparam int HOLD_OFF_CYCLES = 60;
	localparam int CYCLE_LIMIT = 100000;

	// One result transfer as the block presents it.
	typedef struct packed {
		logic granted;
		logic [fqlm_pkg::ID_W-1:0] grant_id;
		logic [fqlm_pkg::ST_W-1:0] code;
		logic queue_empty;
	} grant_t;

	// The scoreboard mirrors the lock queue. Every request transfer updates
	// the mirror and queues the result it must produce; every result
	// transfer is checked against the oldest queued result.
	class lock_queue_scoreboard;
		bit lock_held;
		bit [fqlm_pkg::ID_W-1:0] tail_id;
		bit [fqlm_pkg::ID_W-1:0] holder_id;
		bit [fqlm_pkg::ID_W-1:0] link_id [REQUESTERS];
		bit link_on [REQUESTERS];
		bit enlisted [REQUESTERS];
		grant_t pending_grants [$];
		int mismatches;

		function void note_request(logic o, logic [fqlm_pkg::ID_W-1:0] r);
			grant_t g;
			g = '0;
			g.code = fqlm_pkg::ST_OK;
			if (o == fqlm_pkg::OP_ACQUIRE) begin
				if (r >= REQUESTERS || enlisted[r]) begin
					// The agent is out of range, already holds the lock or already waits.
					g.code = fqlm_pkg::ST_DUP;
				end else begin
					enlisted[r] = 1'b1;
					link_on[r] = 1'b0;
					link_id[r] = '0;
					if (!lock_held) begin
						lock_held = 1'b1;
						tail_id = r;
						holder_id = r;
						g.granted = 1'b1;
						g.grant_id = r;
					end else begin
						link_id[tail_id] = r;
						link_on[tail_id] = 1'b1;
						tail_id = r;
						g.code = fqlm_pkg::ST_QUEUED;
					end
				end
			end else if (r >= REQUESTERS || !lock_held || holder_id != r) begin
				g.code = fqlm_pkg::ST_NOT_HOLDER;
			end else begin
				enlisted[r] = 1'b0;
				if (link_on[r]) begin
					holder_id = link_id[r];
					link_on[r] = 1'b0;
					link_id[r] = '0;
					g.granted = 1'b1;
					g.grant_id = holder_id;
				end else begin
					// Nobody is linked behind the holder, so the queue drains.
					lock_held = 1'b0;
					tail_id = '0;
				end
			end
			g.queue_empty = !lock_held;
			pending_grants.push_back(g);
		endfunction

		function void check_result(grant_t got);
			grant_t want;
			if (pending_grants.size() == 0) begin
				$error("result transfer with no request outstanding: %p", got);
				mismatches++;
				return;
			end
			want = pending_grants.pop_front();
			if (got.granted !== want.granted) begin
				$error("grant_valid: expected %0b, actual %0b", want.granted, got.granted);
				mismatches++;
			end
			if (got.grant_id !== want.grant_id) begin
				$error("grant_to: expected %0d, actual %0d", want.grant_id, got.grant_id);
				mismatches++;
			end
			if (got.code !== want.code) begin
				$error("status: expected %0d, actual %0d", want.code, got.code);
				mismatches++;
			end
			if (got.queue_empty !== want.queue_empty) begin
				$error("queue_empty: expected %0b, actual %0b", want.queue_empty,
					got.queue_empty);
				mismatches++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic op;
	logic [fqlm_pkg::ID_W-1:0] requester;
	logic out_valid;
	logic out_ready;
	logic grant_valid;
	logic [fqlm_pkg::ID_W-1:0] grant_to;
	logic [fqlm_pkg::ST_W-1:0] status;
	logic queue_empty;

	lock_queue_scoreboard sb;

	// When set, neither side inserts idle cycles.
	bit no_gaps = 1'b0;
	// The sender raises this to ask the receiver for a long hold-off.
	bit hold_request = 1'b0;
	int cycle_count = 0;

	fifo_queue_lock_manager_top #(
		.NUM_REQUESTERS(REQUESTERS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.op(op),
		.requester(requester),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.grant_valid(grant_valid),
		.grant_to(grant_to),
		.status(status),
		.queue_empty(queue_empty)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Watchdog: a correct run finishes far below this limit.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// Both channels are sampled at the rising edge. Inputs only move at the
	// falling edge, so the values seen here are settled. The request is
	// noted first; its own result can never arrive in the same cycle.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) begin
				sb.note_request(op, requester);
			end
			if (out_valid && out_ready) begin
				sb.check_result({grant_valid, grant_to, status, queue_empty});
			end
		end
	end

	// Receiver. It stalls at random, except during the gap-free stretch,
	// and on request it holds off for a long, counted stretch so that the
	// block fills up and drops in_ready while the sender keeps offering.
	initial begin
		out_ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (hold_request) begin
				out_ready <= 1'b0;
				for (int k = 1; k < HOLD_OFF_CYCLES; k++) begin
					@(negedge clk);
				end
				hold_request = 1'b0;
			end else begin
				out_ready <= no_gaps || ($urandom_range(99) >= 8);
			end
		end
	end

	// Offers one request, called at a falling edge. Random idle cycles may
	// come first; after the transfer it returns at the next falling edge, so
	// back-to-back calls keep in_valid high without touching it twice.
	task automatic drive_request(input logic o, input logic [fqlm_pkg::ID_W-1:0] r);
		while (!no_gaps && $urandom_range(99) < 8) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		op <= o;
		requester <= r;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
	endtask

	// Picks a random request from the scoreboard's current view, called at a
	// falling edge when the mirror is up to date. Most requests keep the
	// queue moving: the holder releases, or a free agent joins the queue.
	// The remainder is noise, which also covers duplicate acquires and
	// releases by agents that do not hold the lock.
	task automatic pick_request(output logic o, output logic [fqlm_pkg::ID_W-1:0] r);
		int roll;
		int free_ids [$];
		roll = $urandom_range(99);
		for (int i = 0; i < REQUESTERS; i++) begin
			if (!sb.enlisted[i]) free_ids.push_back(i);
		end
		if (sb.lock_held && roll < 32) begin
			o = fqlm_pkg::OP_RELEASE;
			r = sb.holder_id;
		end else if (roll < 78 && free_ids.size() > 0) begin
			o = fqlm_pkg::OP_ACQUIRE;
			r = fqlm_pkg::ID_W'(free_ids[$urandom_range(free_ids.size() - 1)]);
		end else begin
			o = 1'($urandom_range(1));
			r = fqlm_pkg::ID_W'($urandom_range(REQUESTERS - 1));
		end
	endtask

	initial begin
		logic o;
		logic [fqlm_pkg::ID_W-1:0] r;

		sb = new();
		arst_n = 1'b0;
		in_valid = 1'b0;
		op = fqlm_pkg::OP_ACQUIRE;
		requester = '0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed part. An empty queue grants at once, later agents wait in
		// arrival order, and each release by the holder hands over to the
		// next waiter until the last one empties the queue.
		drive_request(fqlm_pkg::OP_ACQUIRE, 4'd0);
		drive_request(fqlm_pkg::OP_ACQUIRE, 4'd0);    // duplicate from the holder
		drive_request(fqlm_pkg::OP_ACQUIRE, 4'd15);
		drive_request(fqlm_pkg::OP_ACQUIRE, 4'd15);   // duplicate from a waiter
		drive_request(fqlm_pkg::OP_ACQUIRE, 4'd7);
		drive_request(fqlm_pkg::OP_RELEASE, 4'd15);   // a waiter is not the holder
		drive_request(fqlm_pkg::OP_RELEASE, 4'd3);    // an outsider is not the holder
		drive_request(fqlm_pkg::OP_RELEASE, 4'd0);    // hands over to agent 15
		drive_request(fqlm_pkg::OP_ACQUIRE, 4'd10);
		drive_request(fqlm_pkg::OP_RELEASE, 4'd15);   // hands over to agent 7
		drive_request(fqlm_pkg::OP_RELEASE, 4'd7);    // hands over to agent 10
		drive_request(fqlm_pkg::OP_RELEASE, 4'd10);   // no successor, queue empties
		drive_request(fqlm_pkg::OP_RELEASE, 4'd10);   // release on an empty queue
		drive_request(fqlm_pkg::OP_RELEASE, 4'd0);
		drive_request(fqlm_pkg::OP_ACQUIRE, 4'd15);
		drive_request(fqlm_pkg::OP_RELEASE, 4'd15);   // grant and release back to back
		drive_request(fqlm_pkg::OP_ACQUIRE, 4'd5);
		drive_request(fqlm_pkg::OP_ACQUIRE, 4'd0);
		drive_request(fqlm_pkg::OP_ACQUIRE, 4'd5);    // the holder asks again
		drive_request(fqlm_pkg::OP_RELEASE, 4'd5);    // hands over to agent 0
		drive_request(fqlm_pkg::OP_RELEASE, 4'd0);
		drive_request(fqlm_pkg::OP_ACQUIRE, 4'd0);    // a former holder may come back
		drive_request(fqlm_pkg::OP_RELEASE, 4'd0);

		// Random part, with two long receiver hold-offs and a stretch in
		// which neither side idles.
		for (int n = 0; n < RANDOM_REQUESTS; n++) begin
			if (n == 150 || n == 650) hold_request = 1'b1;
			no_gaps = (n >= 400 && n < 600);
			pick_request(o, r);
			drive_request(o, r);
		end
		no_gaps = 1'b0;
		in_valid <= 1'b0;

		while (sb.pending_grants.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (sb.mismatches == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

// File: files.f
+incdir+sv
sv/fqlm_pkg.sv
sv/fqlm_front.sv
sv/fqlm_back.sv
sv/fifo_queue_lock_manager_top.sv
verif/fifo_queue_lock_manager_top_tb.sv
